// ===== rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and sizes for the interval task timer pool.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int SLOTS       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

	// queue depths: powers of two
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	localparam logic [1:0] MODE_TICK         = 2'd0;
	localparam logic [1:0] MODE_ADD_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_ADD_ONE_SHOT = 2'd2;
	localparam logic [1:0] MODE_REMOVE       = 2'd3;

	localparam logic [2:0] STAT_FIRED    = 3'd0;
	localparam logic [2:0] STAT_NONE     = 3'd1;
	localparam logic [2:0] STAT_ADDED    = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_REMOVED  = 3'd4;
	localparam logic [2:0] STAT_NO_MATCH = 3'd5;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_ADD,
		CMD_REMOVE
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_WALK,
		ENG_FLUSH
	} eng_state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] now_ms;
		logic [31:0] interval_ms;
		logic [7:0]  task_tag;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
		logic [7:0] tag;
		logic       last;
	} res_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        one_shot;
		logic [31:0] now_ms;
		logic [31:0] interval_ms;
		logic [7:0]  task_tag;
	} cmd_t;

	function automatic logic [3:0] slot_field(input logic [IDX_W-1:0] idx);
		logic [IDX_W+3:0] wide;
		wide = {4'b0, idx};
		return wide[3:0];
	endfunction

endpackage

// ===== rtl/itp_front.sv =====
// ----------------------------------------------------------------------------
// itp_front
// Accepts requests, decodes the mode into a command and queues it for the
// slot engine.
// ----------------------------------------------------------------------------
module itp_front import itp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t req,
	output logic full,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	cmd_t                cmd_in;
	cmd_t                cmd_mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	always_comb begin
		cmd_in.one_shot    = (req.mode == MODE_ADD_ONE_SHOT);
		cmd_in.now_ms      = req.now_ms;
		cmd_in.interval_ms = req.interval_ms;
		cmd_in.task_tag    = req.task_tag;
		unique case (req.mode) inside
			MODE_TICK:                            cmd_in.kind = CMD_TICK;
			MODE_ADD_PERIODIC, MODE_ADD_ONE_SHOT: cmd_in.kind = CMD_ADD;
			MODE_REMOVE:                          cmd_in.kind = CMD_REMOVE;
			default:                              cmd_in.kind = CMD_TICK;
		endcase
	end

	assign full      = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cmd_mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + CQ_CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) cmd_mem_q[wr_ptr_q] <= cmd_in;
	end

endmodule

// ===== rtl/itp_engine.sv =====
// ----------------------------------------------------------------------------
// itp_engine
// Slot table and walker: visits one slot per cycle, while the result queue has room,
// to fire, allocate or free, and emits results into the result queue.
// ----------------------------------------------------------------------------
module itp_engine import itp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res_data
);

	eng_state_t state_q, state_d;
	cmd_t              cur_q;
	logic [IDX_W-1:0]  idx_q;
	logic [FIRE_W-1:0] fire_cnt_q;
	logic              pend_valid_q;
	logic [3:0]        pend_slot_q;
	logic [7:0]        pend_tag_q;

	logic              active_q   [SLOTS];
	logic              one_shot_q [SLOTS];
	logic [7:0]        tag_q      [SLOTS];
	logic [31:0]       interval_q [SLOTS];
	logic [31:0]       last_run_q [SLOTS];

	logic        act;
	logic [31:0] elapsed;
	logic        due;
	logic        free_hit;
	logic        match_hit;
	logic        at_end;
	logic        step;
	logic        fire_we;
	logic        add_we;
	logic        rm_we;

	assign act       = active_q[idx_q];
	assign elapsed   = cur_q.now_ms - last_run_q[idx_q];
	assign due       = act && (elapsed >= interval_q[idx_q])
		&& (fire_cnt_q < FIRE_W'(MAX_RESULTS));
	assign free_hit  = !act;
	assign match_hit = act && (tag_q[idx_q] == cur_q.task_tag);
	assign at_end    = (idx_q == IDX_W'(SLOTS - 1));
	assign step      = (state_q == ENG_WALK) && !res_full;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (cmd_valid) state_d = ENG_WALK;
			end
			ENG_WALK: begin
				if (!res_full) begin
					if ((cur_q.kind == CMD_ADD && free_hit) ||
						(cur_q.kind == CMD_REMOVE && match_hit))
						state_d = ENG_IDLE;
					else if (at_end)
						state_d = ENG_FLUSH;
				end
			end
			ENG_FLUSH: begin
				if (!res_full) state_d = ENG_IDLE;
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_data = '0;
		fire_we  = 1'b0;
		add_we   = 1'b0;
		rm_we    = 1'b0;
		unique case (state_q)
			ENG_IDLE: begin
				cmd_pop = cmd_valid;
			end
			ENG_WALK: begin
				if (!res_full) begin
					unique case (cur_q.kind)
						CMD_TICK: begin
							if (due) begin
								fire_we = 1'b1;
								if (pend_valid_q) begin
									res_push = 1'b1;
									res_data = '{STAT_FIRED, pend_slot_q, pend_tag_q, 1'b0};
								end
							end
						end
						CMD_ADD: begin
							if (free_hit) begin
								add_we   = 1'b1;
								res_push = 1'b1;
								res_data = '{STAT_ADDED, slot_field(idx_q), cur_q.task_tag, 1'b1};
							end
						end
						CMD_REMOVE: begin
							if (match_hit) begin
								rm_we    = 1'b1;
								res_push = 1'b1;
								res_data = '{STAT_REMOVED, slot_field(idx_q), cur_q.task_tag,
									1'b1};
							end
						end
						default: ;
					endcase
				end
			end
			ENG_FLUSH: begin
				if (!res_full) begin
					res_push = 1'b1;
					unique case (cur_q.kind)
						CMD_TICK: begin
							if (pend_valid_q)
								res_data = '{STAT_FIRED, pend_slot_q, pend_tag_q, 1'b1};
							else
								res_data = '{STAT_NONE, 4'd0, 8'd0, 1'b1};
						end
						CMD_ADD:    res_data = '{STAT_FULL, 4'd0, 8'd0, 1'b1};
						CMD_REMOVE: res_data = '{STAT_NO_MATCH, 4'd0, 8'd0, 1'b1};
						default:    res_data = '{STAT_NONE, 4'd0, 8'd0, 1'b1};
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ENG_IDLE;
			idx_q        <= '0;
			fire_cnt_q   <= '0;
			pend_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) active_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				idx_q        <= '0;
				fire_cnt_q   <= '0;
				pend_valid_q <= 1'b0;
			end else if (step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (fire_we) begin
				pend_valid_q <= 1'b1;
				fire_cnt_q   <= fire_cnt_q + FIRE_W'(1);
				if (one_shot_q[idx_q]) active_q[idx_q] <= 1'b0;
			end
			if (add_we) active_q[idx_q] <= 1'b1;
			if (rm_we)  active_q[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
		if (fire_we) begin
			pend_slot_q       <= slot_field(idx_q);
			pend_tag_q        <= tag_q[idx_q];
			last_run_q[idx_q] <= cur_q.now_ms;
		end
		if (add_we) begin
			one_shot_q[idx_q] <= cur_q.one_shot;
			tag_q[idx_q]      <= cur_q.task_tag;
			interval_q[idx_q] <= cur_q.interval_ms;
			last_run_q[idx_q] <= cur_q.now_ms;
		end
	end

endmodule

// ===== rtl/itp_res_queue.sv =====
// ----------------------------------------------------------------------------
// itp_res_queue
// Result queue between the slot engine and the result port.
// ----------------------------------------------------------------------------
module itp_res_queue import itp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_push,
	input  res_t in_data,
	output logic in_full,
	output logic empty,
	input  logic pop,
	output res_t result
);

	res_t                mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign in_full = (cnt_q == RQ_CNT_W'(RQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign result  = mem_q[rd_ptr_q];
	assign do_push = in_push && !in_full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + RQ_CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - RQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= in_data;
	end

endmodule

// ===== rtl/interval_task_timer_pool_top.sv =====
// Flow: the idle engine takes a request from the command queue and then walks the slots;
// add and remove end at the first hit, a tick walks all slots. The single slot walker
// visits one slot per cycle while the result queue has room and takes no new request
// until it is through with the last one.
// Reset: arst_n clears all slot active marks and empties both queues at once.
// ----------------------------------------------------------------------------
// interval_task_timer_pool_top
// Pool of periodic and one-shot timer slots with queue ports on both sides.
// ----------------------------------------------------------------------------
module interval_task_timer_pool_top import itp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t req,
	output logic full,
	output logic empty,
	input  logic pop,
	output res_t result
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic res_full;
	logic res_push;
	res_t res_data;

	itp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req       (req),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	itp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	itp_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (res_push),
		.in_data (res_data),
		.in_full (res_full),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== rtl/itp_checker.sv =====
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on results of the timer pool.
// ----------------------------------------------------------------------------
module itp_checker import itp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input res_t result
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status <= STAT_NO_MATCH))
		else $error("result status out of range");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != STAT_FIRED) |-> result.last)
		else $error("non-fire result without last mark");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == STAT_NONE || result.status == STAT_FULL ||
			result.status == STAT_NO_MATCH)) |-> (result.slot == 4'd0 && result.tag == 8'd0))
		else $error("empty result carries slot or tag");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

endmodule

bind interval_task_timer_pool_top itp_checker u_itp_checker (.*);
